/* rtl/bltr_pkg.sv */
// Shared widths, reset values, register codes and record types of the throttle ramp.
package bltr_pkg;

	localparam int unsigned PULSE_W    = 16;
	localparam int unsigned LEVEL_W    = 3;
	localparam int unsigned RAMP_W     = 16;
	localparam int unsigned IDLE_W     = 24;
	localparam int unsigned LOCK_W     = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// debounce lockout length in ticks
	localparam logic [LOCK_W-1:0] DEBOUNCE_TICKS = 8'd200;

	localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PULSE_OFF         = 3'd0,
		REG_PULSE_LEVEL_ONE   = 3'd1,
		REG_PULSE_LEVEL_TWO   = 3'd2,
		REG_PULSE_LEVEL_THREE = 3'd3,
		REG_PULSE_LEVEL_FOUR  = 3'd4,
		REG_SLEW_STEP         = 3'd5,
		REG_SLEW_PERIOD       = 3'd6,
		REG_AUTO_OFF_LIMIT    = 3'd7
	} cfg_reg_t;

	localparam logic [PULSE_W-1:0] PULSE_OFF_RST     = 16'd8000;
	localparam logic [PULSE_W-1:0] PULSE_ONE_RST     = 16'd9600;
	localparam logic [PULSE_W-1:0] PULSE_TWO_RST     = 16'd10200;
	localparam logic [PULSE_W-1:0] PULSE_THREE_RST   = 16'd11000;
	localparam logic [PULSE_W-1:0] PULSE_FOUR_RST    = 16'd12000;
	localparam logic [PULSE_W-1:0] SLEW_STEP_RST     = 16'd100;
	localparam logic [RAMP_W-1:0]  SLEW_PERIOD_RST   = 16'd50;
	localparam logic [IDLE_W-1:0]  AUTO_OFF_RST      = 24'd360000;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_off;
		logic [PULSE_W-1:0] pulse_one;
		logic [PULSE_W-1:0] pulse_two;
		logic [PULSE_W-1:0] pulse_three;
		logic [PULSE_W-1:0] pulse_four;
		logic [PULSE_W-1:0] slew_step;
		logic [RAMP_W-1:0]  slew_period;
		logic [IDLE_W-1:0]  auto_off_limit;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [PULSE_W-1:0] pulse;
		logic [RAMP_W-1:0]  ramp_elapsed;
		logic [IDLE_W-1:0]  idle_elapsed;
		logic [LOCK_W-1:0]  lockout;
	} state_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_width;
		logic [LEVEL_W-1:0] level;
		logic               at_target;
	} result_t;

	// target pulse width of a level; unused codes fall back to the off width
	function automatic logic [PULSE_W-1:0] target_of(cfg_t cfg, logic [LEVEL_W-1:0] lvl);
		logic [PULSE_W-1:0] t;
		case (lvl)
			LEVEL_ONE:   t = cfg.pulse_one;
			LEVEL_TWO:   t = cfg.pulse_two;
			LEVEL_THREE: t = cfg.pulse_three;
			LEVEL_FOUR:  t = cfg.pulse_four;
			default:     t = cfg.pulse_off;
		endcase
		return t;
	endfunction

endpackage

/* rtl/bltr_tick_if.sv */
// Tick channel: one button sample per transfer.
interface bltr_tick_if;
	logic valid;
	logic ready;
	logic button;

	modport source (output valid, output button, input ready);
	modport sink   (input valid, input button, output ready);
endinterface

/* rtl/bltr_result_if.sv */
// Result channel: pulse width, level and at-target flag per transfer.
interface bltr_result_if;
	logic                             valid;
	logic                             ready;
	logic [bltr_pkg::PULSE_W-1:0]     pulse_width;
	logic [bltr_pkg::LEVEL_W-1:0]     level;
	logic                             at_target;

	modport source (output valid, output pulse_width, output level, output at_target,
		input ready);
	modport sink   (input valid, input pulse_width, input level, input at_target,
		output ready);
endinterface

/* rtl/button_level_throttle_ramp_unit.sv */
// Top level: button-stepped power level with slew-limited pulse width.
//
//  channel | dir | payload                          | transfer when
//  tick    | in  | button                           | tick.valid & tick.ready
//  result  | out | pulse_width, level, at_target    | result.valid & result.ready
//  cfg     | in  | cfg_index, cfg_data              | cfg_we
//
// One tick per clock cycle while tick.ready is high; its result is registered.
// The per-tick update is a single pass of bltr_tick_update feeding the state regs.
// A skid register behind the result register keeps tick.ready high for one extra
// transfer while result is stalled; tick.ready drops only once the skid is full.
// arst_n clears the state and loads the register reset values; no clearing pass.
module button_level_throttle_ramp_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	bltr_tick_if.sink                         tick,
	bltr_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [bltr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bltr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	bltr_pkg::cfg_t    cfg_q;
	bltr_pkg::state_t  state_q;
	bltr_pkg::state_t  state_nxt;
	bltr_pkg::result_t res_nxt;
	bltr_pkg::result_t out_q;
	bltr_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              tick_fire;
	logic              out_fire;

	// configuration writes; every index is a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_off      <= bltr_pkg::PULSE_OFF_RST;
			cfg_q.pulse_one      <= bltr_pkg::PULSE_ONE_RST;
			cfg_q.pulse_two      <= bltr_pkg::PULSE_TWO_RST;
			cfg_q.pulse_three    <= bltr_pkg::PULSE_THREE_RST;
			cfg_q.pulse_four     <= bltr_pkg::PULSE_FOUR_RST;
			cfg_q.slew_step      <= bltr_pkg::SLEW_STEP_RST;
			cfg_q.slew_period    <= bltr_pkg::SLEW_PERIOD_RST;
			cfg_q.auto_off_limit <= bltr_pkg::AUTO_OFF_RST;
		end else if (cfg_we) begin
			unique case (bltr_pkg::cfg_reg_t'(cfg_index))
				bltr_pkg::REG_PULSE_OFF:
					cfg_q.pulse_off <= cfg_data[bltr_pkg::PULSE_W-1:0];
				bltr_pkg::REG_PULSE_LEVEL_ONE:
					cfg_q.pulse_one <= cfg_data[bltr_pkg::PULSE_W-1:0];
				bltr_pkg::REG_PULSE_LEVEL_TWO:
					cfg_q.pulse_two <= cfg_data[bltr_pkg::PULSE_W-1:0];
				bltr_pkg::REG_PULSE_LEVEL_THREE:
					cfg_q.pulse_three <= cfg_data[bltr_pkg::PULSE_W-1:0];
				bltr_pkg::REG_PULSE_LEVEL_FOUR:
					cfg_q.pulse_four <= cfg_data[bltr_pkg::PULSE_W-1:0];
				bltr_pkg::REG_SLEW_STEP:
					cfg_q.slew_step <= cfg_data[bltr_pkg::PULSE_W-1:0];
				bltr_pkg::REG_SLEW_PERIOD:
					cfg_q.slew_period <= cfg_data[bltr_pkg::RAMP_W-1:0];
				bltr_pkg::REG_AUTO_OFF_LIMIT:
					cfg_q.auto_off_limit <= cfg_data[bltr_pkg::IDLE_W-1:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign tick.ready = !skid_valid_q;
	assign tick_fire  = tick.valid && tick.ready;
	assign out_fire   = out_valid_q && result.ready;

	bltr_tick_update u_update (
		.cur    (state_q),
		.cfg    (cfg_q),
		.button (tick.button),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	// tick state advances on every accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.level        <= bltr_pkg::LEVEL_OFF;
			state_q.pulse        <= bltr_pkg::PULSE_OFF_RST;
			state_q.ramp_elapsed <= '0;
			state_q.idle_elapsed <= '0;
			state_q.lockout      <= '0;
		end else if (tick_fire) begin
			state_q <= state_nxt;
		end
	end

	// result register plus skid: valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_fire) begin
					skid_valid_q <= 1'b0;
				end
			end else if (tick_fire) begin
				if (out_valid_q && !result.ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (tick_fire) begin
			if (out_valid_q && !result.ready) begin
				skid_q <= res_nxt;
			end else begin
				out_q <= res_nxt;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.pulse_width = out_q.pulse_width;
	assign result.level       = out_q.level;
	assign result.at_target   = out_q.at_target;

	// skid holds data only behind a full result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register valid with empty result register");

	// level never leaves 0..4
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.level <= bltr_pkg::LEVEL_FOUR)
		else $error("power level out of range");

	// during lockout a transfer leaves the level untouched
	a_lockout_holds_level: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_fire && state_q.lockout != '0) |=> $stable(state_q.level))
		else $error("level changed during debounce lockout");

	// a press outside lockout reloads the lockout counter
	a_press_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_fire && state_q.lockout == '0 && tick.button)
		|=> state_q.lockout == bltr_pkg::DEBOUNCE_TICKS)
		else $error("press did not start lockout");

endmodule

/* rtl/bltr_tick_update.sv */
// Next-state and result logic for one millisecond tick.
module bltr_tick_update (
	input  bltr_pkg::state_t  cur,
	input  bltr_pkg::cfg_t    cfg,
	input  logic              button,
	output bltr_pkg::state_t  nxt,
	output bltr_pkg::result_t res
);

	logic [bltr_pkg::RAMP_W-1:0]  ramp_inc;
	logic [bltr_pkg::IDLE_W-1:0]  idle_inc;
	logic [bltr_pkg::LEVEL_W-1:0] level_n;
	logic [bltr_pkg::IDLE_W-1:0]  idle_n;
	logic [bltr_pkg::LOCK_W-1:0]  lock_n;
	logic [bltr_pkg::RAMP_W-1:0]  ramp_n;
	logic [bltr_pkg::PULSE_W-1:0] pulse_n;
	logic [bltr_pkg::PULSE_W-1:0] target;
	logic                         normal;
	logic                         step;
	logic [bltr_pkg::PULSE_W:0]   up_sum;
	logic [bltr_pkg::PULSE_W:0]   dn_lim;

	// saturating timers
	assign ramp_inc = (cur.ramp_elapsed == '1) ? cur.ramp_elapsed
		: cur.ramp_elapsed + 1'b1;
	assign idle_inc = (cur.idle_elapsed == '1) ? cur.idle_elapsed
		: cur.idle_elapsed + 1'b1;

	assign normal = (cur.lockout == '0) && !button;

	always_comb begin
		level_n = cur.level;
		idle_n  = idle_inc;
		lock_n  = cur.lockout;
		if (cur.lockout != '0) begin
			lock_n = cur.lockout - 1'b1;
		end else if (button) begin
			level_n = (cur.level >= bltr_pkg::LEVEL_FOUR) ? bltr_pkg::LEVEL_OFF
				: cur.level + 1'b1;
			idle_n  = '0;
			lock_n  = bltr_pkg::DEBOUNCE_TICKS;
		end else if (cur.level != bltr_pkg::LEVEL_OFF && idle_inc > cfg.auto_off_limit) begin
			level_n = bltr_pkg::LEVEL_OFF;
		end
	end

	// target of the level this tick ends with
	assign target = bltr_pkg::target_of(cfg, level_n);
	assign step   = normal && (ramp_inc >= cfg.slew_period);
	assign up_sum = {1'b0, cur.pulse} + {1'b0, cfg.slew_step};
	assign dn_lim = {1'b0, target} + {1'b0, cfg.slew_step};

	always_comb begin
		pulse_n = cur.pulse;
		ramp_n  = ramp_inc;
		if (step) begin
			ramp_n = '0;
			if (cur.pulse < target) begin
				pulse_n = (up_sum > {1'b0, target}) ? target : up_sum[bltr_pkg::PULSE_W-1:0];
			end else if (cur.pulse > target) begin
				pulse_n = ({1'b0, cur.pulse} < dn_lim) ? target : cur.pulse - cfg.slew_step;
			end
		end
	end

	assign nxt.level        = level_n;
	assign nxt.pulse        = pulse_n;
	assign nxt.ramp_elapsed = ramp_n;
	assign nxt.idle_elapsed = idle_n;
	assign nxt.lockout      = lock_n;

	assign res.pulse_width = pulse_n;
	assign res.level       = level_n;
	assign res.at_target   = (pulse_n == target);

endmodule
